@@ sv/nbg_pkg.sv @@
// Shared types and constants for the n-body gravity step block.
package nbg_pkg;

  localparam int unsigned POS_W = 32;
  localparam int unsigned MU_W = 40;
  localparam int unsigned DT_W = 32;
  localparam int unsigned ACC_W = 64;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DATA_W = 6;

  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_BODIES = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PIN_FIRST = 1'd1;

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_STEP = 1'b1;

  localparam logic [63:0] ONE_SQ = 64'd65536;
  localparam logic signed [63:0] ACC_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] DV_LIM = 64'd1 << 40;

  // divider request: (num_hi:num_lo) / den, 64-bit quotient, saturating
  typedef struct packed {
    logic start;
    logic [63:0] num_hi;
    logic [63:0] num_lo;
    logic [63:0] den;
  } div_req_t;

  typedef struct packed {
    logic done;
    logic [63:0] quo;
  } div_rsp_t;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    logic signed [31:0] r;
    if (v > 66'sd2147483647) r = 32'sh7FFF_FFFF;
    else if (v < -66'sd2147483648) r = 32'sh8000_0000;
    else r = v[31:0];
    return r;
  endfunction

endpackage

@@ sv/nbg_div.sv @@
// Bit-serial restoring divider, 128 by 64, one quotient bit per cycle.
module nbg_div (
  input  logic clk,
  input  logic rst,
  input  nbg_pkg::div_req_t req,
  output nbg_pkg::div_rsp_t rsp
);
  import nbg_pkg::*;

  logic busy;
  logic [6:0] cnt;
  logic [63:0] rem;
  logic [63:0] lo;
  logic [63:0] den;
  logic [63:0] quo;
  logic [64:0] shifted;
  logic ge;

  assign shifted = {rem, lo[63]};
  assign ge = shifted >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      rsp.done <= 1'b0;
    end else begin
      rsp.done <= 1'b0;
      if (req.start) begin
        if (req.den == 64'd0 || req.num_hi >= req.den) begin
          rsp.quo <= '1;
          rsp.done <= 1'b1;
        end else begin
          busy <= 1'b1;
          cnt <= 7'd64;
          rem <= req.num_hi;
          lo <= req.num_lo;
          den <= req.den;
          quo <= '0;
        end
      end else if (busy) begin
        rem <= ge ? 64'(shifted - {1'b0, den}) : shifted[63:0];
        lo <= {lo[62:0], 1'b0};
        quo <= {quo[62:0], ge};
        cnt <= cnt - 7'd1;
        if (cnt == 7'd1) begin
          busy <= 1'b0;
          rsp.done <= 1'b1;
          rsp.quo <= {quo[62:0], ge};
        end
      end
    end
  end
endmodule

@@ sv/nbody_gravity_step_top.sv @@
// Top level of the n-body gravity step: stores, sequencer, shared divider.
//
//  channel | signals                                     | direction
//  in      | in_valid/in_ready, kind..step_duration      | request in
//  out     | out_valid/out_ready, out_index..last        | request out
//  cfg     | cfg_valid/cfg_ready, cfg_index, cfg_data    | register write
//
// A load is taken and in_ready stays high. A step with active bodies drops in_ready:
// each ordered pair of distinct bodies runs the square root loop, three divider
// passes with issue (gravity term, x and y components), two multiply steps and
// bookkeeping; a self pair and a pair within 1.0 are skipped early; then come
// the velocity and position passes and one emit per body. Body stores are
// register arrays read at one or two entries per cycle. Reset clears control
// only; stores are undefined until loaded. While results wait on out_ready
// the sequencer holds.
module nbody_gravity_step_top #(
  parameter int unsigned MAX_BODIES = 32
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  logic kind,
  input  logic [4:0] body_index,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  input  logic signed [31:0] vel_x,
  input  logic signed [31:0] vel_y,
  input  logic [39:0] grav_param,
  input  logic [31:0] step_duration,
  output logic out_valid,
  input  logic out_ready,
  output logic [4:0] out_index,
  output logic signed [31:0] out_pos_x,
  output logic signed [31:0] out_pos_y,
  output logic signed [31:0] out_vel_x,
  output logic signed [31:0] out_vel_y,
  output logic last,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [nbg_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [nbg_pkg::CFG_DATA_W-1:0] cfg_data
);
  import nbg_pkg::*;

  localparam int unsigned IW = (MAX_BODIES > 1) ? $clog2(MAX_BODIES) : 1;
  localparam int unsigned CW = $clog2(MAX_BODIES + 1);

  typedef enum logic [14:0] {
    S_IDLE  = 15'b000000000000001,
    S_PAIR  = 15'b000000000000010,
    S_DIFF  = 15'b000000000000100,
    S_SQRT  = 15'b000000000001000,
    S_GDIV  = 15'b000000000010000,
    S_GWAIT = 15'b000000000100000,
    S_CDIV  = 15'b000000001000000,
    S_CWAIT = 15'b000000010000000,
    S_NEXTJ = 15'b000000100000000,
    S_VEL   = 15'b000001000000000,
    S_VELW  = 15'b000010000000000,
    S_POS   = 15'b000100000000000,
    S_POSW  = 15'b001000000000000,
    S_EMIT  = 15'b010000000000000,
    S_CMUL  = 15'b100000000000000
  } state_t;

  state_t state;

  logic signed [31:0] px_mem [MAX_BODIES];
  logic signed [31:0] py_mem [MAX_BODIES];
  logic signed [31:0] vx_mem [MAX_BODIES];
  logic signed [31:0] vy_mem [MAX_BODIES];
  logic [39:0] mu_mem [MAX_BODIES];
  logic signed [63:0] ax_mem [MAX_BODIES];
  logic signed [63:0] ay_mem [MAX_BODIES];

  logic [5:0] active_bodies;
  logic pin_first_body;
  logic [CW-1:0] n;
  logic [31:0] dt;
  logic [IW-1:0] bi, bj;

  // per-pair working registers
  logic signed [31:0] xi, yi, xj, yj;
  logic [39:0] muj;
  logic signed [32:0] dx, dy;
  logic [63:0] dsq, sq_n, sq_res, sq_bit, g;
  logic [5:0] sq_cnt;
  logic comp_y;
  logic signed [63:0] ax, ay;
  logic [64:0] gp_lo;

  // update pass
  logic signed [31:0] rd_v, rd_p;
  logic signed [63:0] rd_a;
  logic upd_y;

  div_req_t dreq;
  div_rsp_t drsp;

  nbg_div u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));

  logic [CW-1:0] n_sat;
  assign n_sat = (32'(active_bodies) > MAX_BODIES) ? CW'(MAX_BODIES)
                                                   : CW'(active_bodies);

  assign in_ready = (state == S_IDLE);
  assign cfg_ready = (state == S_IDLE);

  // squared distance with saturation
  logic [63:0] sx2, sy2, dsq_c;
  logic [64:0] dsq_sum;
  logic [32:0] adx, ady;
  assign adx = dx[32] ? 33'(-dx) : 33'(dx);
  assign ady = dy[32] ? 33'(-dy) : 33'(dy);
  assign sx2 = 64'(adx) * 64'(adx);
  assign sy2 = 64'(ady) * 64'(ady);
  assign dsq_sum = {1'b0, sx2} + {1'b0, sy2};
  assign dsq_c = dsq_sum[64] ? '1 : dsq_sum[63:0];

  // component: g * |d| (128 bit) from two 32x33 partial products, low half
  // in S_CMUL, high half in S_CDIV, through one shared multiplier
  logic [32:0] dmag;
  logic [31:0] g_half;
  logic [64:0] gp_part;
  logic [127:0] gprod;
  assign dmag = comp_y ? ady : adx;
  assign g_half = (state == S_CDIV) ? g[63:32] : g[31:0];
  assign gp_part = 65'(g_half) * 65'(dmag);
  assign gprod = ({63'd0, gp_part} << 32) + {63'd0, gp_lo};

  logic signed [63:0] term, acc_cur, acc_sum;
  logic [63:0] qsat;
  logic dneg;
  assign dneg = comp_y ? dy[32] : dx[32];
  assign qsat = (drsp.quo > 64'(ACC_MAX)) ? 64'(ACC_MAX) : drsp.quo;
  assign term = dneg ? -$signed(qsat) : $signed(qsat);
  assign acc_cur = comp_y ? ay : ax;
  always_comb begin
    if (term > 0 && acc_cur > ACC_MAX - term) acc_sum = ACC_MAX;
    else if (term < 0 && acc_cur < -ACC_MAX - term) acc_sum = -ACC_MAX;
    else acc_sum = acc_cur + term;
  end

  // velocity and position updates
  logic [63:0] amag, dv_mag;
  logic [95:0] dv_hi, dv_lo;
  logic signed [31:0] v_new, p_new;
  logic [31:0] vmag;
  logic [63:0] dp;
  assign amag = rd_a[63] ? 64'(-rd_a) : 64'(rd_a);
  assign dv_hi = {64'd0, amag[63:32]} * {64'd0, dt};
  assign dv_lo = ({64'd0, amag[31:0]} * {64'd0, dt}) >> 32;
  always_comb begin
    dv_mag = 64'(dv_hi) + 64'(dv_lo);
    if (dv_mag > DV_LIM) dv_mag = DV_LIM;
  end
  assign v_new = sat32(66'(rd_v) + (rd_a[63] ? -$signed({2'b0, dv_mag})
                                             : $signed({2'b0, dv_mag})));
  assign vmag = rd_v[31] ? 32'(-rd_v) : 32'(rd_v);
  assign dp = 64'(({32'd0, vmag} * {32'd0, dt}) >> 32);
  assign p_new = sat32(66'(rd_p) + (rd_v[31] ? -$signed({2'b0, dp})
                                             : $signed({2'b0, dp})));

  logic [63:0] sq_try;
  assign sq_try = sq_res + sq_bit;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      active_bodies <= 6'd1;
      pin_first_body <= 1'b1;
      out_valid <= 1'b0;
      dreq.start <= 1'b0;
    end else begin
      dreq.start <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (cfg_valid) begin
            unique case (cfg_index)
              REG_ACTIVE_BODIES: active_bodies <= cfg_data;
              REG_PIN_FIRST: pin_first_body <= cfg_data[0];
              default: ;
            endcase
          end
          if (in_valid) begin
            if (kind == KIND_LOAD) begin
              if (32'(body_index) < MAX_BODIES) begin
                px_mem[IW'(body_index)] <= pos_x;
                py_mem[IW'(body_index)] <= pos_y;
                vx_mem[IW'(body_index)] <= vel_x;
                vy_mem[IW'(body_index)] <= vel_y;
                mu_mem[IW'(body_index)] <= grav_param;
              end
            end else if (n_sat != '0) begin
              n <= n_sat;
              dt <= step_duration;
              bi <= '0;
              bj <= '0;
              ax <= '0;
              ay <= '0;
              state <= S_PAIR;
            end
          end
        end
        S_PAIR: begin
          xi <= px_mem[bi];
          yi <= py_mem[bi];
          xj <= px_mem[bj];
          yj <= py_mem[bj];
          muj <= mu_mem[bj];
          state <= (bi == bj) ? S_NEXTJ : S_DIFF;
        end
        S_DIFF: begin
          dx <= 33'(xj) - 33'(xi);
          dy <= 33'(yj) - 33'(yi);
          state <= S_SQRT;
          sq_cnt <= 6'd0;
        end
        S_SQRT: begin
          if (sq_cnt == 6'd0) begin
            dsq <= dsq_c;
            sq_n <= dsq_c;
            sq_res <= '0;
            sq_bit <= 64'd1 << 62;
            sq_cnt <= 6'd1;
            if (dsq_c <= ONE_SQ) state <= S_NEXTJ;
          end else if (sq_bit == '0) begin
            state <= S_GDIV;
          end else begin
            if (sq_n >= sq_try) begin
              sq_n <= sq_n - sq_try;
              sq_res <= (sq_res >> 1) + sq_bit;
            end else begin
              sq_res <= sq_res >> 1;
            end
            sq_bit <= sq_bit >> 2;
          end
        end
        S_GDIV: begin
          dreq.start <= 1'b1;
          dreq.num_hi <= 64'(muj >> 32);
          dreq.num_lo <= {muj[31:0], 32'd0};
          dreq.den <= dsq;
          state <= S_GWAIT;
        end
        S_GWAIT: begin
          if (drsp.done) begin
            g <= drsp.quo;
            comp_y <= 1'b0;
            state <= S_CMUL;
          end
        end
        S_CMUL: begin
          gp_lo <= gp_part;
          state <= S_CDIV;
        end
        S_CDIV: begin
          dreq.start <= 1'b1;
          dreq.num_hi <= gprod[127:64];
          dreq.num_lo <= gprod[63:0];
          dreq.den <= sq_res;
          state <= S_CWAIT;
        end
        S_CWAIT: begin
          if (drsp.done) begin
            if (comp_y) begin
              ay <= acc_sum;
              state <= S_NEXTJ;
            end else begin
              ax <= acc_sum;
              comp_y <= 1'b1;
              state <= S_CMUL;
            end
          end
        end
        S_NEXTJ: begin
          if (CW'(bj) == n - CW'(1)) begin
            ax_mem[bi] <= ax;
            ay_mem[bi] <= ay;
            ax <= '0;
            ay <= '0;
            bj <= '0;
            if (CW'(bi) == n - CW'(1)) begin
              bi <= '0;
              upd_y <= 1'b0;
              state <= S_VEL;
            end else begin
              bi <= bi + IW'(1);
              state <= S_PAIR;
            end
          end else begin
            bj <= bj + IW'(1);
            state <= S_PAIR;
          end
        end
        S_VEL: begin
          rd_v <= upd_y ? vy_mem[bi] : vx_mem[bi];
          rd_a <= upd_y ? ay_mem[bi] : ax_mem[bi];
          state <= S_VELW;
        end
        S_VELW: begin
          if (upd_y) vy_mem[bi] <= v_new;
          else vx_mem[bi] <= v_new;
          upd_y <= !upd_y;
          state <= S_VEL;
          if (upd_y) begin
            if (CW'(bi) == n - CW'(1)) begin
              bi <= '0;
              state <= S_POS;
            end else begin
              bi <= bi + IW'(1);
            end
          end
        end
        S_POS: begin
          rd_v <= upd_y ? vy_mem[bi] : vx_mem[bi];
          rd_p <= upd_y ? py_mem[bi] : px_mem[bi];
          state <= S_POSW;
        end
        S_POSW: begin
          if (!(bi == '0 && pin_first_body)) begin
            if (upd_y) py_mem[bi] <= p_new;
            else px_mem[bi] <= p_new;
          end
          upd_y <= !upd_y;
          state <= S_POS;
          if (upd_y) begin
            if (CW'(bi) == n - CW'(1)) begin
              bi <= '0;
              state <= S_EMIT;
            end else begin
              bi <= bi + IW'(1);
            end
          end
        end
        S_EMIT: begin
          if (!out_valid || out_ready) begin
            if (out_valid && last) begin
              out_valid <= 1'b0;
              state <= S_IDLE;
            end else begin
              out_valid <= 1'b1;
              out_index <= 5'(bi);
              out_pos_x <= px_mem[bi];
              out_pos_y <= py_mem[bi];
              out_vel_x <= vx_mem[bi];
              out_vel_y <= vy_mem[bi];
              last <= (CW'(bi) == n - CW'(1));
              bi <= bi + IW'(1);
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

@@ sv/nbg_check.sv @@
// Port-level checker for the n-body gravity step, with its bind.
module nbg_check (
  input logic clk,
  input logic rst,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic last,
  input logic [4:0] out_index,
  input logic cfg_ready
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_index))
    else $error("result dropped while stalled");
  a_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready)
    else $error("input taken while results pending");
  a_cfg: assert property (@(posedge clk) disable iff (rst)
    cfg_ready == in_ready)
    else $error("config port open while busy");
  a_first: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> out_index == 5'd0)
    else $error("run does not start at body zero");
  a_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && last |=> !out_valid)
    else $error("result after the last body of a run");
endmodule

bind nbody_gravity_step_top nbg_check u_nbg_check (
  .clk(clk), .rst(rst), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .last(last),
  .out_index(out_index), .cfg_ready(cfg_ready)
);

@@ tb/nbody_gravity_step_top_test.sv @@
// Self-checking testbench for nbody_gravity_step_top.
module nbody_gravity_step_top_test;
  import nbg_pkg::*;

  localparam int NB = 32;
  localparam longint CYCLE_LIMIT = 6000000;
  localparam longint ACC_TOP = 64'sh7FFF_FFFF_FFFF_FFFF;

  // one request on the input channel
  typedef struct {
    logic kind;
    logic [4:0] body_index;
    logic signed [31:0] pos_x, pos_y, vel_x, vel_y;
    logic [39:0] grav_param;
    logic [31:0] step_duration;
  } body_req_t;

  // one body report on the output channel
  typedef struct {
    logic [4:0] idx;
    logic signed [31:0] pos_x, pos_y, vel_x, vel_y;
    logic last;
  } body_rsp_t;

  // Scoreboard: own copy of the body stores, predicts each step's reports.
  class gravity_board;
    logic signed [31:0] px[NB], py[NB], vx[NB], vy[NB];
    logic [39:0] mu[NB];
    logic [5:0] active_n;
    logic pin_first;
    body_rsp_t exp_bodies[$];
    int fails;

    function new();
      active_n = 6'd1;
      pin_first = 1'b1;
      fails = 0;
      for (int i = 0; i < NB; i++) begin
        px[i] = 0; py[i] = 0; vx[i] = 0; vy[i] = 0; mu[i] = 0;
      end
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      if (idx == REG_ACTIVE_BODIES) active_n = val;
      else if (idx == REG_PIN_FIRST) pin_first = val[0];
    endfunction

    function int pending();
      return exp_bodies.size();
    endfunction

    function logic [63:0] div_sat(logic [127:0] num, logic [63:0] den);
      logic [127:0] q;
      q = num / {64'd0, den};
      if (q[127:64] != 0) return '1;
      return q[63:0];
    endfunction

    function logic [63:0] root_floor(logic [63:0] v);
      logic [63:0] res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
        if (v >= res + b) begin
          v = v - (res + b);
          res = (res >> 1) + b;
        end else begin
          res = res >> 1;
        end
        b = b >> 2;
      end
      return res;
    endfunction

    function longint accel_term(logic [63:0] g, longint d, logic [63:0] span);
      logic [63:0] mag, q;
      mag = (d < 0) ? -d : d;
      q = div_sat({64'd0, g} * {64'd0, mag}, span);
      if (q > ACC_TOP) q = ACC_TOP;
      return (d < 0) ? -longint'(q) : longint'(q);
    endfunction

    function longint acc_add(longint a, longint b);
      logic signed [65:0] s;
      s = 66'(a) + 66'(b);
      if (s > 66'(ACC_TOP)) return ACC_TOP;
      if (s < -66'(ACC_TOP)) return -ACC_TOP;
      return longint'(s);
    endfunction

    function logic signed [31:0] clip32(longint v);
      if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
      if (v < -64'sd2147483648) return 32'sh8000_0000;
      return v[31:0];
    endfunction

    // magnitude * dt / 2^32, signed back
    function longint scaled(longint a, logic [31:0] dt, logic [63:0] lim);
      logic [63:0] mag;
      logic [127:0] p;
      mag = (a < 0) ? -a : a;
      p = ({64'd0, mag} * {96'd0, dt}) >> 32;
      if (p > {64'd0, lim}) p = {64'd0, lim};
      return (a < 0) ? -longint'(p[63:0]) : longint'(p[63:0]);
    endfunction

    function void note_request(body_req_t r);
      int n;
      longint ax[NB], ay[NB];
      longint dx, dy;
      logic [63:0] sx, sy, dsq, span, g;
      logic [64:0] sum;
      body_rsp_t e;
      if (r.kind == KIND_LOAD) begin
        px[r.body_index] = r.pos_x; py[r.body_index] = r.pos_y;
        vx[r.body_index] = r.vel_x; vy[r.body_index] = r.vel_y;
        mu[r.body_index] = r.grav_param;
        return;
      end
      n = (active_n > NB) ? NB : active_n;
      for (int i = 0; i < n; i++) begin
        ax[i] = 0; ay[i] = 0;
        for (int j = 0; j < n; j++) begin
          if (i == j) continue;
          dx = longint'(px[j]) - longint'(px[i]);
          dy = longint'(py[j]) - longint'(py[i]);
          sx = (dx < 0) ? -dx : dx;
          sy = (dy < 0) ? -dy : dy;
          sum = {1'b0, sx * sx} + {1'b0, sy * sy};
          dsq = sum[64] ? '1 : sum[63:0];
          if (dsq <= ONE_SQ) continue;   // closer than 1.0: pair skipped
          span = root_floor(dsq);
          g = div_sat({56'd0, mu[j], 32'd0}, dsq);
          ax[i] = acc_add(ax[i], accel_term(g, dx, span));
          ay[i] = acc_add(ay[i], accel_term(g, dy, span));
        end
      end
      for (int i = 0; i < n; i++) begin
        vx[i] = clip32(longint'(vx[i]) + scaled(ax[i], r.step_duration, DV_LIM));
        vy[i] = clip32(longint'(vy[i]) + scaled(ay[i], r.step_duration, DV_LIM));
      end
      for (int i = 0; i < n; i++) begin
        if (i == 0 && pin_first) continue;
        px[i] = clip32(longint'(px[i]) + scaled(vx[i], r.step_duration, '1));
        py[i] = clip32(longint'(py[i]) + scaled(vy[i], r.step_duration, '1));
      end
      for (int i = 0; i < n; i++) begin
        e.idx = 5'(i); e.pos_x = px[i]; e.pos_y = py[i];
        e.vel_x = vx[i]; e.vel_y = vy[i]; e.last = (i == n - 1);
        exp_bodies.insert(exp_bodies.size(), e);
      end
    endfunction

    function void check_body(body_rsp_t got);
      body_rsp_t e;
      if (exp_bodies.size() == 0) begin
        $error("body report %0d with nothing expected", got.idx);
        fails++;
        return;
      end
      e = exp_bodies.pop_front();
      if (got.idx !== e.idx) begin
        $error("out_index expected %0d got %0d", e.idx, got.idx); fails++;
      end
      if (got.pos_x !== e.pos_x) begin
        $error("out_pos_x expected %0d got %0d", e.pos_x, got.pos_x); fails++;
      end
      if (got.pos_y !== e.pos_y) begin
        $error("out_pos_y expected %0d got %0d", e.pos_y, got.pos_y); fails++;
      end
      if (got.vel_x !== e.vel_x) begin
        $error("out_vel_x expected %0d got %0d", e.vel_x, got.vel_x); fails++;
      end
      if (got.vel_y !== e.vel_y) begin
        $error("out_vel_y expected %0d got %0d", e.vel_y, got.vel_y); fails++;
      end
      if (got.last !== e.last) begin
        $error("last expected %0d got %0d", e.last, got.last); fails++;
      end
    endfunction
  endclass

  // DUT signals; every input has a known value from time zero
  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic kind = KIND_LOAD;
  logic [4:0] body_index = '0;
  logic signed [31:0] pos_x = '0, pos_y = '0, vel_x = '0, vel_y = '0;
  logic [39:0] grav_param = '0;
  logic [31:0] step_duration = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [4:0] out_index;
  logic signed [31:0] out_pos_x, out_pos_y, out_vel_x, out_vel_y;
  logic last;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  nbody_gravity_step_top dut (.*);

  gravity_board board = new();

  int send_idle_pct = 0;       // chance of a gap before each request
  int recv_stall_pct = 0;      // chance of out_ready low in a cycle
  int hold_left = 0;           // long receiver hold-off, in cycles
  logic [NB-1:0] loaded = '0;  // bodies written so far; steps never read others
  longint cycles = 0;

  initial begin
    forever #2 clk = ~clk;
  end

  // Cycle guard: a hung block ends the run here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Receiver: random stalls, plus the long hold-off when one is asked.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Monitor: every handshake feeds the scoreboard, sampled at the edge.
  always @(posedge clk) begin
    body_req_t r;
    body_rsp_t g;
    if (!rst) begin
      if (cfg_valid && cfg_ready) board.write_reg(cfg_index, cfg_data);
      if (in_valid && in_ready) begin
        r.kind = kind; r.body_index = body_index;
        r.pos_x = pos_x; r.pos_y = pos_y; r.vel_x = vel_x; r.vel_y = vel_y;
        r.grav_param = grav_param; r.step_duration = step_duration;
        board.note_request(r);
      end
      if (out_valid && out_ready) begin
        g.idx = out_index; g.pos_x = out_pos_x; g.pos_y = out_pos_y;
        g.vel_x = out_vel_x; g.vel_y = out_vel_y; g.last = last;
        board.check_body(g);
      end
    end
  end

  // Offer one request; returns at the edge where it is taken.
  task automatic send_req(body_req_t r);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    kind <= r.kind; body_index <= r.body_index;
    pos_x <= r.pos_x; pos_y <= r.pos_y; vel_x <= r.vel_x; vel_y <= r.vel_y;
    grav_param <= r.grav_param; step_duration <= r.step_duration;
    do @(posedge clk); while (!in_ready);
    if (r.kind == KIND_LOAD) loaded[r.body_index] = 1'b1;
  endtask

  // Holds cfg_valid high; the caller drops it after its last write.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Quiet point: all reports back, then a margin for loads and empty steps.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (board.pending() > 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic set_regs(logic [5:0] n, logic [5:0] pin_word);
    drain();
    write_reg(REG_ACTIVE_BODIES, n);
    write_reg(REG_PIN_FIRST, pin_word);
    cfg_valid <= 1'b0;
  endtask

  function automatic bit all_loaded(int n);
    for (int i = 0; i < n; i++) begin
      if (!loaded[i]) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic logic signed [31:0] pick_pos();
    unique case ($urandom_range(0, 4))
      0: return $urandom;
      1: return $signed($urandom_range(0, 511)) - 256;          // inside 1.0
      2: return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      default: return $signed($urandom_range(0, 1 << 20)) - (1 << 19);
    endcase
  endfunction

  function automatic logic signed [31:0] pick_vel();
    unique case ($urandom_range(0, 2))
      0: return $urandom;
      default: return $signed($urandom_range(0, 1 << 18)) - (1 << 17);
    endcase
  endfunction

  function automatic body_req_t load_req(int idx);
    body_req_t r;
    r.kind = KIND_LOAD;
    r.body_index = 5'(idx);
    r.pos_x = pick_pos(); r.pos_y = pick_pos();
    r.vel_x = pick_vel(); r.vel_y = pick_vel();
    r.grav_param = $urandom_range(0, 1) ? 40'({$urandom, $urandom})
                                        : 40'($urandom_range(0, 1 << 24));
    r.step_duration = $urandom;   // don't care on a load, but toggled anyway
    return r;
  endfunction

  function automatic body_req_t step_req(logic [31:0] dt);
    body_req_t r;
    r = load_req(0);
    r.kind = KIND_STEP;
    r.body_index = 5'($urandom);
    r.step_duration = dt;
    return r;
  endfunction

  function automatic logic [31:0] pick_dt();
    unique case ($urandom_range(0, 3))
      0: return $urandom;
      1: return 32'($urandom_range(0, 1 << 16));
      default: return 32'($urandom_range(0, 1 << 25));
    endcase
  endfunction

  // Random traffic: mostly loads into a few bodies, steps once they are loaded.
  task automatic random_items(int count, int max_n);
    body_req_t r;
    int n;
    for (int k = 0; k < count; k++) begin
      n = (board.active_n > NB) ? NB : board.active_n;
      if ($urandom_range(0, 99) < 35 && all_loaded(n)) begin
        r = step_req(pick_dt());
      end else if (!all_loaded(n)) begin
        r = load_req($urandom_range(0, n - 1));
      end else begin
        r = load_req($urandom_range(0, 9) == 0 ? $urandom_range(0, 31) : $urandom_range(0, max_n));
      end
      send_req(r);
    end
  endtask

  initial begin
    body_req_t r;
    int pcts[4][2] = '{'{0, 0}, '{45, 0}, '{0, 45}, '{14, 14}};
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: field extremes, pinned single body, skipped close pair,
    // zero and full step duration, zero active bodies.
    r = load_req(0);
    r.pos_x = 0; r.pos_y = 0; r.vel_x = 32'sh7FFF_FFFF; r.vel_y = 32'sh8000_0000;
    r.grav_param = '1;
    send_req(r);
    r = load_req(1);
    r.pos_x = 32'sh7FFF_FFFF; r.pos_y = 32'sh7FFF_FFFF; r.vel_x = 0; r.vel_y = -1;
    r.grav_param = '1;
    send_req(r);
    r = load_req(2);
    r.pos_x = 32'sh8000_0000; r.pos_y = 32'sh8000_0000; r.grav_param = 0;
    send_req(r);
    r = load_req(3);
    r.pos_x = 100; r.pos_y = 50; r.grav_param = 40'd1 << 30;   // within 1.0 of body 0
    send_req(r);
    send_req(step_req('1));              // reset config: one body, pinned
    set_regs(6'd4, 6'd0);
    send_req(step_req('1));
    send_req(step_req('0));
    send_req(step_req(32'h0100_0000));
    set_regs(6'd0, 6'd1);
    send_req(step_req('1));              // no bodies active: no report
    set_regs(6'd2, 6'd3);
    send_req(step_req(32'h0001_0000));
    r = load_req(31);
    r.pos_x = -1; r.pos_y = 1;
    send_req(r);

    // Random phases over the idle settings.
    foreach (pcts[p]) begin
      set_regs($urandom_range(0, 9) == 0 ? 6'd0 : 6'($urandom_range(1, 4)), 6'($urandom));
      send_idle_pct = pcts[p][0];
      recv_stall_pct = pcts[p][1];
      random_items(15, 5);
    end

    // Back pressure: receiver holds off while steps pile up at the input.
    send_idle_pct = 0;
    recv_stall_pct = 0;
    set_regs(6'd3, 6'd0);
    while (!(&loaded[2:0])) send_req(load_req($urandom_range(0, 2)));
    hold_left = 8000;
    repeat (4) send_req(step_req(pick_dt()));
    drain();

    // Full set: all 32 bodies, then an out-of-range count that saturates.
    for (int i = 0; i < NB; i++) send_req(load_req(i));
    set_regs(6'd32, 6'd1);
    send_req(step_req(32'h0000_1000));
    set_regs(6'd63, 6'd0);
    send_req(step_req(32'h0000_1000));

    drain();
    repeat (100) @(posedge clk);
    if (board.fails == 0 && board.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
sv/nbg_pkg.sv
sv/nbg_div.sv
sv/nbody_gravity_step_top.sv
sv/nbg_check.sv
tb/nbody_gravity_step_top_test.sv
